// ===== rtl/core/shs_pkg.sv =====
// shs_pkg: shared types, constants and round functions for the sha-256 stream hasher
// no dependencies; imported by shs_ctrl, shs_datapath and sha256_stream_hasher
`timescale 1ns / 1ps
`default_nettype none

package shs_pkg;

  // how message words are formed while a block is compressed
  typedef enum logic [1:0] {
    PAD_NONE,    // plain data block
    PAD_FIRST,   // data, 0x80, zeros; the length goes into a further block
    PAD_FINAL,   // data, 0x80, zeros and the 64-bit bit count
    PAD_LENONLY  // zeros and the 64-bit bit count
  } pad_mode_e;

  // controller to datapath
  typedef struct packed {
    logic       wr_byte;
    logic       load_vars;
    logic       round_en;
    logic       add_chain;
    logic       clear_state;
    logic [3:0] rd_addr;
    logic [5:0] round_idx;
    pad_mode_e  pad_mode;
    logic [2:0] out_sel;
  } shs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic block_end;  // the next byte fills the block
    logic pos_high;   // fill position is 56 or more, no room for the length
  } shs_stat_t;

  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_SLOT = 6'd56;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [2:0] LAST_WORD_IDX = 3'd7;

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  function automatic logic [31:0] sha_ch(input logic [31:0] e, input logic [31:0] f,
                                         input logic [31:0] g);
    return g ^ (e & (f ^ g));
  endfunction

  function automatic logic [31:0] sha_maj(input logic [31:0] a, input logic [31:0] b,
                                          input logic [31:0] c);
    return (a & b) | (c & (a | b));
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sha256_stream_hasher.sv =====
// sha256_stream_hasher: top level of the byte-wide sha-256 hasher with digest output register
// depends on shs_pkg, shs_ctrl and shs_datapath
`timescale 1ns / 1ps
`default_nettype none

// usage
// - input channel: one transfer per message byte (byte_present_i high), optionally with
//   end_of_message_i; a transfer with byte_present_i low and end_of_message_i high ends
//   the message without a byte, one with both low does nothing
// - a byte that does not complete a 64-byte block is taken without a stall; a byte that completes
//   one stalls the input for the compression: a load step, 64 rounds (one round per
//   cycle through the single round unit) and a chain add step
// - end of message: a padding decision step, then one compression, or two
//   when fewer than 9 bytes remain in the block; the first digest word is
//   registered from the emit state after the last compression, once the output is free
// - output channel: eight transfers, word_index_o 0..7, last_word_o on the eighth; one
//   word per cycle when the receiver does not stall, readout pauses while it stalls
// - after the eighth word is loaded the chain words and bit count return to their
//   initial values and the input opens again, even while the last word still waits
// - reset clears the controller, chain words and bit count at once; no clearing pass
module sha256_stream_hasher
  import shs_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [7:0]  data_byte_i,
  input  wire         byte_present_i,
  input  wire         end_of_message_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  shs_cmd_t    cmd;
  shs_stat_t   stat;
  logic        out_free;
  logic        out_load;
  logic [31:0] digest_sel;

  logic        out_valid_q;
  logic [31:0] digest_q;
  logic [2:0]  index_q;
  logic        last_q;

  // the output register can take a word when empty or when its word leaves now
  assign out_free = !out_valid_q || !out_stall_i;

  shs_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .byte_present_i   (byte_present_i),
    .end_of_message_i (end_of_message_i),
    .stat_i           (stat),
    .out_free_i       (out_free),
    .out_load_o       (out_load),
    .cmd_o            (cmd)
  );

  shs_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .data_byte_i (data_byte_i),
    .stat_o      (stat),
    .digest_o    (digest_sel)
  );

  // output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload, held while the receiver stalls
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      digest_q <= digest_sel;
      index_q  <= cmd.out_sel;
      last_q   <= (cmd.out_sel == LAST_WORD_IDX);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign digest_word_o = digest_q;
  assign word_index_o  = index_q;
  assign last_word_o   = last_q;

endmodule

`default_nettype wire

// ===== rtl/core/shs_ctrl.sv =====
// shs_ctrl: sequencer for byte intake, block compression, padding and digest readout
// depends on shs_pkg; drives shs_datapath through shs_cmd_t
`timescale 1ns / 1ps
`default_nettype none

module shs_ctrl
  import shs_pkg::*;
(
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       in_valid_i,
  output logic      in_stall_o,
  input  wire       byte_present_i,
  input  wire       end_of_message_i,
  input  wire shs_stat_t stat_i,
  input  wire       out_free_i,
  output logic      out_load_o,
  output shs_cmd_t  cmd_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_FINISH = 3'd1;
  localparam logic [2:0] ST_LOAD   = 3'd2;
  localparam logic [2:0] ST_ROUND  = 3'd3;
  localparam logic [2:0] ST_ADD    = 3'd4;
  localparam logic [2:0] ST_EMIT   = 3'd5;

  logic [2:0] state_q, state_d;
  logic [5:0] round_q, round_d;
  pad_mode_e  mode_q, mode_d;
  logic       fin_q, fin_d;
  logic [2:0] idx_q, idx_d;

  always_comb begin
    state_d = state_q;
    round_d = round_q;
    mode_d  = mode_q;
    fin_d   = fin_q;
    idx_d   = idx_q;
    in_stall_o = 1'b1;
    out_load_o = 1'b0;
    cmd_o = '0;
    cmd_o.pad_mode  = mode_q;
    cmd_o.round_idx = round_q;
    cmd_o.out_sel   = idx_q;
    cmd_o.rd_addr   = round_q[3:0] + 4'd1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.wr_byte = byte_present_i;
          if (byte_present_i && stat_i.block_end) begin
            mode_d  = PAD_NONE;
            fin_d   = end_of_message_i;
            state_d = ST_LOAD;
          end else if (end_of_message_i) begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        mode_d  = stat_i.pos_high ? PAD_FIRST : PAD_FINAL;
        fin_d   = 1'b0;
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        cmd_o.load_vars = 1'b1;
        cmd_o.rd_addr   = 4'd0;
        round_d = 6'd0;
        state_d = ST_ROUND;
      end
      ST_ROUND: begin
        cmd_o.round_en = 1'b1;
        round_d = round_q + 6'd1;
        if (round_q == LAST_ROUND) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        cmd_o.add_chain = 1'b1;
        case (mode_q)
          PAD_NONE: begin
            state_d = fin_q ? ST_FINISH : ST_IDLE;
          end
          PAD_FIRST: begin
            mode_d  = PAD_LENONLY;
            state_d = ST_LOAD;
          end
          default: begin
            idx_d   = 3'd0;
            state_d = ST_EMIT;
          end
        endcase
      end
      ST_EMIT: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          idx_d = idx_q + 3'd1;
          if (idx_q == LAST_WORD_IDX) begin
            cmd_o.clear_state = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      round_q <= 6'd0;
      mode_q  <= PAD_NONE;
      fin_q   <= 1'b0;
      idx_q   <= 3'd0;
    end else begin
      state_q <= state_d;
      round_q <= round_d;
      mode_q  <= mode_d;
      fin_q   <= fin_d;
      idx_q   <= idx_d;
    end
  end

`ifndef SYNTHESIS
  a_round_to_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND && round_q == LAST_ROUND) |=> (state_q == ST_ADD))
    else $error("compression did not close after the last round");

  a_full_block_compresses: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && in_valid_i && byte_present_i && stat_i.block_end)
    |=> (state_q == ST_LOAD && mode_q == PAD_NONE))
    else $error("full block did not start a compression");

  a_emit_ends_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load_o && idx_q == LAST_WORD_IDX) |=> (state_q == ST_IDLE))
    else $error("digest readout did not return to idle");

  a_len_block_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ADD && mode_q == PAD_FIRST)
    |=> (state_q == ST_LOAD && mode_q == PAD_LENONLY))
    else $error("length block missing after overflow pad block");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/shs_datapath.sv =====
// shs_datapath: block memory, message schedule, round logic, chain words and bit count
// depends on shs_pkg; controlled by shs_ctrl through shs_cmd_t
`timescale 1ns / 1ps
`default_nettype none

module shs_datapath
  import shs_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire shs_cmd_t cmd_i,
  input  wire  [7:0]  data_byte_i,
  output shs_stat_t   stat_o,
  output logic [31:0] digest_o
);

  logic [31:0] block_q [16];
  logic [31:0] rdata_q;
  logic [31:0] chain_q [8];
  logic [31:0] var_q [8];
  logic [31:0] sched_q [16];
  logic [63:0] bits_q;

  logic [5:0]  fill;
  logic [5:0]  byte_pos;
  logic [7:0]  byte_v;
  logic [31:0] msg_word;
  logic [31:0] w_new;
  logic [31:0] t1;
  logic [31:0] t2;
  logic        use_len;

  // fill position is the byte count modulo the block size
  assign fill = bits_q[8:3];
  assign stat_o.block_end = (fill == 6'd63);
  assign stat_o.pos_high  = (fill >= LEN_SLOT);

  // block memory, byte lanes big-endian within a word
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_byte) begin
      block_q[fill[5:2]][{~fill[1:0], 3'b000} +: 8] <= data_byte_i;
    end
    rdata_q <= block_q[cmd_i.rd_addr];
  end

  // message word with padding applied on the fly
  assign use_len = (cmd_i.pad_mode == PAD_FINAL) || (cmd_i.pad_mode == PAD_LENONLY);

  always_comb begin
    msg_word = '0;
    byte_pos = '0;
    byte_v   = '0;
    for (int j = 0; j < 4; j++) begin
      byte_pos = {cmd_i.round_idx[3:0], 2'(j)};
      case (cmd_i.pad_mode)
        PAD_NONE: byte_v = rdata_q[8*(3-j) +: 8];
        PAD_LENONLY: byte_v = 8'h00;
        default: begin
          if (byte_pos < fill) begin
            byte_v = rdata_q[8*(3-j) +: 8];
          end else if (byte_pos == fill) begin
            byte_v = PAD_BYTE;
          end else begin
            byte_v = 8'h00;
          end
        end
      endcase
      msg_word[8*(3-j) +: 8] = byte_v;
    end
    if (use_len && cmd_i.round_idx[3:0] == 4'd14) begin
      msg_word = bits_q[63:32];
    end else if (use_len && cmd_i.round_idx[3:0] == 4'd15) begin
      msg_word = bits_q[31:0];
    end
  end

  assign w_new = (cmd_i.round_idx[5:4] == 2'b00) ? msg_word :
                 small_sigma1(sched_q[1]) + sched_q[6] + small_sigma0(sched_q[14]) +
                 sched_q[15];

  assign t1 = var_q[7] + big_sigma1(var_q[4]) + sha_ch(var_q[4], var_q[5], var_q[6]) +
              SHA_K[cmd_i.round_idx] + w_new;
  assign t2 = big_sigma0(var_q[0]) + sha_maj(var_q[0], var_q[1], var_q[2]);

  // working variables and schedule window
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_vars) begin
      for (int k = 0; k < 8; k++) begin
        var_q[k] <= chain_q[k];
      end
    end else if (cmd_i.round_en) begin
      var_q[0] <= t1 + t2;
      var_q[1] <= var_q[0];
      var_q[2] <= var_q[1];
      var_q[3] <= var_q[2];
      var_q[4] <= var_q[3] + t1;
      var_q[5] <= var_q[4];
      var_q[6] <= var_q[5];
      var_q[7] <= var_q[6];
    end
    if (cmd_i.round_en) begin
      sched_q[0] <= w_new;
      for (int k = 1; k < 16; k++) begin
        sched_q[k] <= sched_q[k-1];
      end
    end
  end

  // chain words and bit count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 8; k++) begin
        chain_q[k] <= SHA_IV[k];
      end
      bits_q <= '0;
    end else begin
      if (cmd_i.clear_state) begin
        for (int k = 0; k < 8; k++) begin
          chain_q[k] <= SHA_IV[k];
        end
        bits_q <= '0;
      end else begin
        if (cmd_i.add_chain) begin
          for (int k = 0; k < 8; k++) begin
            chain_q[k] <= chain_q[k] + var_q[k];
          end
        end
        if (cmd_i.wr_byte) begin
          bits_q <= bits_q + 64'd8;
        end
      end
    end
  end

  assign digest_o = chain_q[cmd_i.out_sel];

endmodule

`default_nettype wire

// ===== sim/sha256_stream_hasher_tb.sv =====
// sha256_stream_hasher_tb: self-checking testbench for the byte-wide sha-256 stream hasher
// needs only the rtl (sha256_stream_hasher and what it pulls in); holds its own sha-256 model
`timescale 1ns / 1ps

module sha256_stream_hasher_tb;

  // sha-256 initial hash values and round constants, kept apart from the rtl tables
  localparam logic [31:0] HASH_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam int LEN_OFFSET = 56;
  localparam int DIGEST_WORDS = 8;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        is_last;
  } digest_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        byte_present_i = 1'b0;
  logic        end_of_message_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        last_word_o;

  // predictor state
  logic [31:0] chain_hash [8];
  logic [7:0]  msg_block [64];
  logic [5:0]  block_fill;
  logic [63:0] bit_total;

  digest_word_t digest_q[$];
  int err_count = 0;
  int items_sent = 0;
  bit no_idle = 1'b0;
  int hold_left = 0;
  int stall_left = 0;

  sha256_stream_hasher uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .byte_present_i   (byte_present_i),
    .end_of_message_i (end_of_message_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .digest_word_o    (digest_word_o),
    .word_index_o     (word_index_o),
    .last_word_o      (last_word_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- sha-256 predictor

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void hash_restart();
    int k;
    for (k = 0; k < 8; k++) chain_hash[k] = HASH_IV[k];
    for (k = 0; k < 64; k++) msg_block[k] = 8'h00;
    block_fill = '0;
    bit_total = '0;
  endfunction

  // full 64-round compression of msg_block into chain_hash
  function automatic void compress_msg_block();
    logic [31:0] w [64];
    logic [31:0] va, vb, vc, vd, ve, vf, vg, vh, t1, t2, s0, s1;
    int r;
    for (r = 0; r < 16; r++)
      w[r] = {msg_block[4*r], msg_block[4*r+1], msg_block[4*r+2], msg_block[4*r+3]};
    for (r = 16; r < 64; r++) begin
      s0 = ror32(w[r-15], 7) ^ ror32(w[r-15], 18) ^ (w[r-15] >> 3);
      s1 = ror32(w[r-2], 17) ^ ror32(w[r-2], 19) ^ (w[r-2] >> 10);
      w[r] = w[r-16] + s0 + w[r-7] + s1;
    end
    va = chain_hash[0]; vb = chain_hash[1]; vc = chain_hash[2]; vd = chain_hash[3];
    ve = chain_hash[4]; vf = chain_hash[5]; vg = chain_hash[6]; vh = chain_hash[7];
    for (r = 0; r < 64; r++) begin
      t1 = vh + (ror32(ve, 6) ^ ror32(ve, 11) ^ ror32(ve, 25)) + ((ve & vf) ^ (~ve & vg))
           + ROUND_K[r] + w[r];
      t2 = (ror32(va, 2) ^ ror32(va, 13) ^ ror32(va, 22)) + ((va & vb) ^ (va & vc) ^ (vb & vc));
      vh = vg; vg = vf; vf = ve; ve = vd + t1;
      vd = vc; vc = vb; vb = va; va = t1 + t2;
    end
    chain_hash[0] += va; chain_hash[1] += vb; chain_hash[2] += vc; chain_hash[3] += vd;
    chain_hash[4] += ve; chain_hash[5] += vf; chain_hash[6] += vg; chain_hash[7] += vh;
  endfunction

  // absorb one accepted transfer; on end of message pad, finish and queue the digest
  function automatic void absorb_item(input logic [7:0] data, input logic present,
                                      input logic ends);
    logic [63:0] len_bits;
    digest_word_t dw;
    int pos, k;
    if (present) begin
      msg_block[block_fill] = data;
      bit_total += 64'd8;
      block_fill += 6'd1;
      if (block_fill == 6'd0) compress_msg_block();
    end
    if (ends) begin
      len_bits = bit_total;
      pos = int'(block_fill);
      msg_block[pos] = PAD_MARK;
      for (k = pos + 1; k < 64; k++) msg_block[k] = 8'h00;
      // no room left for the length: an extra block of zeros carries it
      if (pos >= LEN_OFFSET) begin
        compress_msg_block();
        for (k = 0; k < 64; k++) msg_block[k] = 8'h00;
      end
      for (k = 0; k < 8; k++) msg_block[LEN_OFFSET + k] = len_bits[63 - 8*k -: 8];
      compress_msg_block();
      for (k = 0; k < DIGEST_WORDS; k++) begin
        dw.word = chain_hash[k];
        dw.index = k[2:0];
        dw.is_last = (k == DIGEST_WORDS - 1);
        digest_q.push_back(dw);
      end
      hash_restart();
    end
  endfunction

  // ---------------------------------------------------------------- idling

  // mostly none or short, now and then a long one
  function automatic int pick_idle();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  // receiver: a long hold requested by a test wins, otherwise random stall runs
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left = hold_left - 1;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left = stall_left - 1;
    end else if (!no_idle && $urandom_range(99) < 25) begin
      out_stall_i <= 1'b1;
      stall_left = pick_idle();
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- digest checker

  always @(posedge clk_i) begin
    digest_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (digest_q.size() == 0) begin
        err_count++;
        $display("%0t: digest word %h index %0d with none expected",
                 $time, digest_word_o, word_index_o);
      end else begin
        want = digest_q.pop_front();
        if (digest_word_o !== want.word) begin
          err_count++;
          $display("%0t: digest_word expected %h actual %h", $time, want.word, digest_word_o);
        end
        if (word_index_o !== want.index) begin
          err_count++;
          $display("%0t: word_index expected %0d actual %0d", $time, want.index, word_index_o);
        end
        if (last_word_o !== want.is_last) begin
          err_count++;
          $display("%0t: last_word expected %0b actual %0b", $time, want.is_last, last_word_o);
        end
      end
    end
  end

  // ---------------------------------------------------------------- sender

  // valid stays high between back-to-back transfers so it is never lowered and raised
  // in the same step; any wait that advances time must go through drain_digests
  task automatic send_item(input logic [7:0] data, input logic present, input logic ends);
    int gap;
    gap = pick_idle();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= data;
    byte_present_i <= present;
    end_of_message_i <= ends;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    absorb_item(data, present, ends);
    if (present || ends) items_sent++;
  endtask

  // random bytes, some idle transfers mixed in, end either on the last byte or alone
  task automatic send_message(input int len);
    bit end_on_byte;
    int i;
    end_on_byte = (len > 0) && ($urandom_range(1) == 1);
    for (i = 0; i < len; i++) begin
      if ($urandom_range(99) < 8) send_item(8'($urandom_range(255)), 1'b0, 1'b0);
      send_item(8'($urandom_range(255)), 1'b1, end_on_byte && (i == len - 1));
    end
    if (!end_on_byte) send_item(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  task automatic drain_digests();
    in_valid_i <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_empty_message();
    send_item(8'hff, 1'b0, 1'b1);
  endtask

  // idle transfers change nothing; a byte may carry the end itself
  task automatic test_idle_and_byte_with_end();
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'hff, 1'b1, 1'b1);
  endtask

  task automatic test_short_vectors();
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h5a, 1'b1, 1'b1);
  endtask

  // one message near the length slot first, then a random mix of short and long ones
  task automatic test_random_messages();
    int start, len;
    start = items_sent;
    no_idle = 1'b0;
    send_message($urandom_range(64, 55));
    while (items_sent - start < 80) begin
      no_idle = ($urandom_range(4) == 0);
      len = ($urandom_range(9) < 2) ? $urandom_range(70, 50) : $urandom_range(12, 0);
      send_message(len);
    end
    no_idle = 1'b0;
  endtask

  // receiver holds off while messages keep coming, so the hasher backs up into its input
  task automatic test_output_backpressure();
    int i;
    hold_left = 500;
    for (i = 0; i < 3; i++) send_message($urandom_range(6, 1));
    drain_digests();
  endtask

  // sender waits for every digest word before starting the next message
  task automatic test_sender_pause();
    send_message($urandom_range(10, 1));
    drain_digests();
    send_message($urandom_range(10, 0));
  endtask

  initial begin
    hash_restart();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_message();
    test_idle_and_byte_with_end();
    test_short_vectors();
    test_random_messages();
    test_output_backpressure();
    test_sender_pause();
    drain_digests();
    repeat (20) @(posedge clk_i);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/shs_pkg.sv
rtl/core/shs_ctrl.sv
rtl/core/shs_datapath.sv
rtl/core/sha256_stream_hasher.sv
sim/sha256_stream_hasher_tb.sv
